// File: design/seconds_to_calendar_date_defines.svh
// Assertion macros used by the calendar converter RTL.
`ifndef SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define STCD_CHECK(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define STCD_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/stcd_pkg.sv
// Types, constants, microcode program and calendar tables for the calendar converter.
package stcd_pkg;

  localparam int SECS_W   = 32;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  localparam int DAYS_W = 16;  // day count since the epoch, 1-based
  localparam int QUO_W  = 16;
  localparam int DIV_W  = 17;
  localparam int YLEN_W = 9;
  localparam int MLEN_W = 5;

  localparam logic [DIV_W-1:0] SECS_PER_DAY  = DIV_W'(86400);
  localparam logic [DIV_W-1:0] SECS_PER_HOUR = DIV_W'(3600);
  localparam logic [DIV_W-1:0] SECS_PER_MIN  = DIV_W'(60);

  // Reciprocal division: q = ((x >> pre) * magic) >> shift, exact over each operand range.
  localparam int RCP_T_W   = 25;
  localparam int RCP_M_W   = 26;
  localparam int RCP_P_W   = RCP_T_W + RCP_M_W;
  localparam int RCP_PRE_W = 3;
  localparam int RCP_SH_W  = 6;

  localparam logic [RCP_PRE_W-1:0] DAY_PRE    = RCP_PRE_W'(7);
  localparam logic [RCP_M_W-1:0]   DAY_MAGIC  = RCP_M_W'(50903317);
  localparam logic [RCP_SH_W-1:0]  DAY_SHIFT  = RCP_SH_W'(35);
  localparam logic [RCP_PRE_W-1:0] HOUR_PRE   = RCP_PRE_W'(4);
  localparam logic [RCP_M_W-1:0]   HOUR_MAGIC = RCP_M_W'(9321);
  localparam logic [RCP_SH_W-1:0]  HOUR_SHIFT = RCP_SH_W'(21);
  localparam logic [RCP_PRE_W-1:0] MIN_PRE    = RCP_PRE_W'(2);
  localparam logic [RCP_M_W-1:0]   MIN_MAGIC  = RCP_M_W'(1093);
  localparam logic [RCP_SH_W-1:0]  MIN_SHIFT  = RCP_SH_W'(14);

  localparam logic [YEAR_W-1:0] BASE_YEAR = YEAR_W'(1970);
  localparam logic [6:0]        BASE_C100 = 7'd70;  // year within its century
  localparam logic [1:0]        BASE_CENT = 2'd3;   // century number mod 4

  localparam logic [YLEN_W-1:0] DAYS_COMMON = YLEN_W'(365);
  localparam logic [YLEN_W-1:0] DAYS_LEAP   = YLEN_W'(366);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_SAVE_DAYS,
    OP_SAVE_HOUR,
    OP_SAVE_MS,
    OP_YEAR,
    OP_MONTH,
    OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    DSEL_DAY,
    DSEL_HOUR,
    DSEL_MIN
  } dsel_t;

  // Repeat the current step while the condition holds, else go to the target.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_YEAR_MORE,
    COND_MONTH_MORE,
    COND_OUT_BUSY
  } cond_t;

  localparam int UC_DEPTH = 10;
  localparam int UC_AW    = $clog2(UC_DEPTH);

  localparam logic [UC_AW-1:0] A_IDLE      = UC_AW'(0);
  localparam logic [UC_AW-1:0] A_DIV_DAY   = UC_AW'(1);
  localparam logic [UC_AW-1:0] A_SAVE_DAYS = UC_AW'(2);
  localparam logic [UC_AW-1:0] A_DIV_HOUR  = UC_AW'(3);
  localparam logic [UC_AW-1:0] A_SAVE_HOUR = UC_AW'(4);
  localparam logic [UC_AW-1:0] A_DIV_MIN   = UC_AW'(5);
  localparam logic [UC_AW-1:0] A_SAVE_MS   = UC_AW'(6);
  localparam logic [UC_AW-1:0] A_YEAR      = UC_AW'(7);
  localparam logic [UC_AW-1:0] A_MONTH     = UC_AW'(8);
  localparam logic [UC_AW-1:0] A_OUT       = UC_AW'(9);

  typedef struct packed {
    op_t              op;
    dsel_t            dsel;
    cond_t            cond;
    logic [UC_AW-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t   op;
    dsel_t dsel;
    logic  en;
  } ctrl_t;

  typedef struct packed {
    logic year_more;
    logic month_more;
  } status_t;

  typedef struct packed {
    logic [RCP_PRE_W-1:0] pre;
    logic [RCP_M_W-1:0]   magic;
    logic [RCP_SH_W-1:0]  shift;
  } rcp_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } result_t;

  function automatic uword_t make_uword(op_t op, dsel_t dsel, cond_t cond,
                                        logic [UC_AW-1:0] target);
    uword_t w;
    w.op     = op;
    w.dsel   = dsel;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Control store.
  function automatic uword_t ucode(logic [UC_AW-1:0] addr);
    uword_t w;
    unique case (addr)
      A_IDLE:      w = make_uword(OP_LOAD, DSEL_DAY, COND_NO_INPUT, A_DIV_DAY);
      A_DIV_DAY:   w = make_uword(OP_DIV, DSEL_DAY, COND_NEVER, A_SAVE_DAYS);
      A_SAVE_DAYS: w = make_uword(OP_SAVE_DAYS, DSEL_DAY, COND_NEVER, A_DIV_HOUR);
      A_DIV_HOUR:  w = make_uword(OP_DIV, DSEL_HOUR, COND_NEVER, A_SAVE_HOUR);
      A_SAVE_HOUR: w = make_uword(OP_SAVE_HOUR, DSEL_HOUR, COND_NEVER, A_DIV_MIN);
      A_DIV_MIN:   w = make_uword(OP_DIV, DSEL_MIN, COND_NEVER, A_SAVE_MS);
      A_SAVE_MS:   w = make_uword(OP_SAVE_MS, DSEL_MIN, COND_NEVER, A_YEAR);
      A_YEAR:      w = make_uword(OP_YEAR, DSEL_DAY, COND_YEAR_MORE, A_MONTH);
      A_MONTH:     w = make_uword(OP_MONTH, DSEL_DAY, COND_MONTH_MORE, A_OUT);
      A_OUT:       w = make_uword(OP_OUT, DSEL_DAY, COND_OUT_BUSY, A_IDLE);
      default:     w = make_uword(OP_NOP, DSEL_DAY, COND_NEVER, A_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic [DIV_W-1:0] divisor(dsel_t dsel);
    logic [DIV_W-1:0] d;
    unique case (dsel)
      DSEL_DAY:  d = SECS_PER_DAY;
      DSEL_HOUR: d = SECS_PER_HOUR;
      DSEL_MIN:  d = SECS_PER_MIN;
      default:   d = SECS_PER_DAY;
    endcase
    return d;
  endfunction

  function automatic rcp_t reciprocal(dsel_t dsel);
    rcp_t r;
    unique case (dsel)
      DSEL_DAY:  r = '{pre: DAY_PRE, magic: DAY_MAGIC, shift: DAY_SHIFT};
      DSEL_HOUR: r = '{pre: HOUR_PRE, magic: HOUR_MAGIC, shift: HOUR_SHIFT};
      DSEL_MIN:  r = '{pre: MIN_PRE, magic: MIN_MAGIC, shift: MIN_SHIFT};
      default:   r = '{pre: DAY_PRE, magic: DAY_MAGIC, shift: DAY_SHIFT};
    endcase
    return r;
  endfunction

  function automatic logic [MLEN_W-1:0] month_days(logic [MONTH_W-1:0] m, logic leap);
    logic [MLEN_W-1:0] len;
    unique case (m)
      4'd2:                   len = leap ? MLEN_W'(29) : MLEN_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11: len = MLEN_W'(30);
      default:                len = MLEN_W'(31);
    endcase
    return len;
  endfunction

endpackage

// File: design/stcd_if.sv
// Valid/ready channel interfaces for the seconds input and the date result.
interface stcd_in_if;
  logic                          valid;
  logic                          ready;
  logic [stcd_pkg::SECS_W-1:0]   epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface stcd_out_if;
  logic                          valid;
  logic                          ready;
  logic [stcd_pkg::YEAR_W-1:0]   year;
  logic [stcd_pkg::MONTH_W-1:0]  month;
  logic [stcd_pkg::DAY_W-1:0]    day;
  logic [stcd_pkg::HOUR_W-1:0]   hour;
  logic [stcd_pkg::MINUTE_W-1:0] minute;
  logic [stcd_pkg::SECOND_W-1:0] second;

  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day, input hour,
                  input minute, input second, output ready);
endinterface

// File: design/stcd_datapath.sv
// Datapath: reciprocal-multiply divider, year and month subtraction, time fields.
module stcd_datapath (
  input  logic                          clk,
  input  stcd_pkg::ctrl_t               ctrl,
  input  logic [stcd_pkg::SECS_W-1:0]   epoch_seconds,
  output stcd_pkg::status_t             status,
  output stcd_pkg::result_t             result
);

  logic [stcd_pkg::SECS_W-1:0]   acc;
  logic [stcd_pkg::QUO_W-1:0]    quo;
  logic [stcd_pkg::DAYS_W-1:0]   days;
  logic [stcd_pkg::YEAR_W-1:0]   year;
  logic [6:0]                    yr_c100;
  logic [1:0]                    yr_cent;
  logic [stcd_pkg::MONTH_W-1:0]  month;
  logic [stcd_pkg::HOUR_W-1:0]   hour;
  logic [stcd_pkg::MINUTE_W-1:0] minute;
  logic [stcd_pkg::SECOND_W-1:0] second;

  stcd_pkg::rcp_t                rcp;
  logic [stcd_pkg::SECS_W-1:0]   acc_sh;
  logic [stcd_pkg::RCP_P_W-1:0]  prod;
  logic [stcd_pkg::RCP_P_W-1:0]  prod_sh;
  logic [stcd_pkg::SECS_W-1:0]   qd;
  logic [stcd_pkg::SECS_W-1:0]   rem;
  logic                          leap;
  logic [stcd_pkg::YLEN_W-1:0]   ylen;
  logic [stcd_pkg::MLEN_W-1:0]   mlen;

  always_comb begin
    // Quotient by reciprocal multiplication; remainder from the stored quotient.
    rcp     = stcd_pkg::reciprocal(ctrl.dsel);
    acc_sh  = acc >> rcp.pre;
    prod    = {{(stcd_pkg::RCP_P_W - stcd_pkg::RCP_T_W){1'b0}},
               acc_sh[stcd_pkg::RCP_T_W-1:0]} *
              {{(stcd_pkg::RCP_P_W - stcd_pkg::RCP_M_W){1'b0}}, rcp.magic};
    prod_sh = prod >> rcp.shift;
    qd      = {{(stcd_pkg::SECS_W - stcd_pkg::QUO_W){1'b0}}, quo} *
              {{(stcd_pkg::SECS_W - stcd_pkg::DIV_W){1'b0}}, stcd_pkg::divisor(ctrl.dsel)};
    rem     = acc - qd;
    // Leap if divisible by 4, except century years not divisible by 400.
    leap    = (year[1:0] == 2'd0) && ((yr_c100 != 7'd0) || (yr_cent == 2'd0));
    ylen    = leap ? stcd_pkg::DAYS_LEAP : stcd_pkg::DAYS_COMMON;
    mlen    = stcd_pkg::month_days(month, leap);
    status.year_more  = days > {{(stcd_pkg::DAYS_W - stcd_pkg::YLEN_W){1'b0}}, ylen};
    status.month_more = days > {{(stcd_pkg::DAYS_W - stcd_pkg::MLEN_W){1'b0}}, mlen};
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      unique case (ctrl.op)
        stcd_pkg::OP_LOAD: begin
          acc     <= epoch_seconds;
          quo     <= '0;
          year    <= stcd_pkg::BASE_YEAR;
          yr_c100 <= stcd_pkg::BASE_C100;
          yr_cent <= stcd_pkg::BASE_CENT;
          month   <= stcd_pkg::MONTH_W'(1);
        end
        stcd_pkg::OP_DIV: begin
          quo <= prod_sh[stcd_pkg::QUO_W-1:0];
        end
        stcd_pkg::OP_SAVE_DAYS: begin
          days <= quo + stcd_pkg::DAYS_W'(1);
          acc  <= rem;
        end
        stcd_pkg::OP_SAVE_HOUR: begin
          hour <= quo[stcd_pkg::HOUR_W-1:0];
          acc  <= rem;
        end
        stcd_pkg::OP_SAVE_MS: begin
          minute <= quo[stcd_pkg::MINUTE_W-1:0];
          second <= rem[stcd_pkg::SECOND_W-1:0];
        end
        stcd_pkg::OP_YEAR: begin
          if (status.year_more) begin
            days <= days - {{(stcd_pkg::DAYS_W - stcd_pkg::YLEN_W){1'b0}}, ylen};
            year <= year + stcd_pkg::YEAR_W'(1);
            // Advance year-in-century, carry into the century count.
            if (yr_c100 == 7'd99) begin
              yr_c100 <= '0;
              yr_cent <= yr_cent + 2'd1;
            end else begin
              yr_c100 <= yr_c100 + 7'd1;
            end
          end
        end
        stcd_pkg::OP_MONTH: begin
          if (status.month_more) begin
            days  <= days - {{(stcd_pkg::DAYS_W - stcd_pkg::MLEN_W){1'b0}}, mlen};
            month <= month + stcd_pkg::MONTH_W'(1);
          end
        end
        stcd_pkg::OP_NOP, stcd_pkg::OP_OUT: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign result.year   = year;
  assign result.month  = month;
  assign result.day    = days[stcd_pkg::DAY_W-1:0];
  assign result.hour   = hour;
  assign result.minute = minute;
  assign result.second = second;

endmodule

// File: design/seconds_to_calendar_date.sv
// Converts a count of seconds since 1970-01-01 00:00:00 to date and time of day.
//
// req channel: one item carries epoch_seconds, accepted when valid and ready are both
// high. ready is high only while the sequencer sits at its idle step.
// rsp channel: one item per request with year, month, day, hour, minute, second,
// held in an output register until taken.
//
// A microcoded sequencer steps through a ten-word control store. A shared
// reciprocal-multiply divider splits off days, hours and minutes, each with a
// divide step for the quotient and a save step for the remainder; the year step
// subtracts one year length per cycle, the month step one month length per cycle.
// One item is in flight at a time; the next can be taken at the idle step, in the
// cycle after the result is loaded.
// A new item may be accepted and processed while the last result waits; if rsp
// still stalls when the next result is ready, the sequencer holds at its output
// step. Synchronous reset returns the sequencer to idle and empties the output
// register; no clearing pass is needed.
`include "seconds_to_calendar_date_defines.svh"

module seconds_to_calendar_date (
  input  logic              clk,
  input  logic              rst,
  stcd_in_if.sink           req,
  stcd_out_if.source        rsp
);

  logic [stcd_pkg::UC_AW-1:0] pc;
  logic [stcd_pkg::UC_AW-1:0] pc_next;
  logic                       out_valid;
  logic                       out_valid_next;
  stcd_pkg::result_t          out_res;

  stcd_pkg::uword_t           uword;
  stcd_pkg::ctrl_t            ctrl;
  stcd_pkg::status_t          status;
  stcd_pkg::result_t          result;
  logic                       out_busy;
  logic                       cond_true;
  logic                       out_load;

  stcd_datapath u_datapath (
    .clk           (clk),
    .ctrl          (ctrl),
    .epoch_seconds (req.epoch_seconds),
    .status        (status),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= stcd_pkg::A_IDLE;
      out_valid <= 1'b0;
    end else begin
      pc        <= pc_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= result;
    end
  end

  always_comb begin
    uword    = stcd_pkg::ucode(pc);
    out_busy = out_valid && !rsp.ready;

    unique case (uword.cond)
      stcd_pkg::COND_NEVER:      cond_true = 1'b0;
      stcd_pkg::COND_NO_INPUT:   cond_true = !req.valid;
      stcd_pkg::COND_YEAR_MORE:  cond_true = status.year_more;
      stcd_pkg::COND_MONTH_MORE: cond_true = status.month_more;
      stcd_pkg::COND_OUT_BUSY:   cond_true = out_busy;
      default:                   cond_true = 1'b0;
    endcase

    // Repeat the step while its condition holds, else jump to its target.
    pc_next = cond_true ? pc : uword.target;

    ctrl.op   = uword.op;
    ctrl.dsel = uword.dsel;
    unique case (uword.op)
      stcd_pkg::OP_LOAD: ctrl.en = req.valid;
      stcd_pkg::OP_OUT:  ctrl.en = !out_busy;
      default:           ctrl.en = 1'b1;
    endcase

    out_load = (uword.op == stcd_pkg::OP_OUT) && !out_busy;

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign req.ready  = pc == stcd_pkg::A_IDLE;
  assign rsp.valid  = out_valid;
  assign rsp.year   = out_res.year;
  assign rsp.month  = out_res.month;
  assign rsp.day    = out_res.day;
  assign rsp.hour   = out_res.hour;
  assign rsp.minute = out_res.minute;
  assign rsp.second = out_res.second;

  `STCD_CHECK_NEXT(a_start_div, clk, rst, req.valid && req.ready, pc == stcd_pkg::A_DIV_DAY,
                   "accepted item did not start the day division")
  `STCD_CHECK_NEXT(a_load_from_out, clk, rst, !rsp.valid,
                   !rsp.valid || $past(pc) == stcd_pkg::A_OUT,
                   "result appeared outside the output step")
  `STCD_CHECK_NEXT(a_hold_stalled, clk, rst, out_busy, rsp.valid && $stable(out_res),
                   "stalled result changed")
  `STCD_CHECK(a_fields_range, clk, rst, rsp.valid,
              rsp.month >= 4'd1 && rsp.month <= 4'd12 && rsp.day >= 5'd1 &&
              rsp.hour <= 5'd23 && rsp.minute <= 6'd59 && rsp.second <= 6'd59,
              "result field out of range")

endmodule

// File: verif/tb_seconds_to_calendar_date.sv
// Testbench for the seconds-to-calendar-date converter: queued stimulus, random stalls, date check.
`timescale 1ns / 1ps

module tb_seconds_to_calendar_date;

  typedef struct {
    logic [stcd_pkg::SECS_W-1:0] secs;
    bit                          drain;  // wait for all dates before presenting this item
  } secs_item_t;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CALM_TAIL    = 120;  // items left in the queue when idling stops
  localparam int N_DIRECTED   = 22;

  // Range ends, day/hour/minute edges, leap rules, last day of a year.
  localparam logic [stcd_pkg::SECS_W-1:0] DIRECTED_SECS [N_DIRECTED] = '{
    32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
    32'd86400, 32'd31449600, 32'd31535999, 32'd31536000, 32'd68169600,
    32'd94607999, 32'd951782400, 32'd978307199, 32'd4107542399,
    32'd4107542400, 32'd2147483647, 32'd2147483648, 32'hAAAA_AAAA,
    32'h5555_5555, 32'd4294944000
  };

  logic clk;
  logic rst;

  stcd_in_if  secs_ch ();
  stcd_out_if date_ch ();

  seconds_to_calendar_date dut (
    .clk (clk),
    .rst (rst),
    .req (secs_ch.sink),
    .rsp (date_ch.source)
  );

  secs_item_t        pending_secs[$];
  stcd_pkg::result_t dates_due[$];
  bit                secs_taken;
  int unsigned       send_gap;
  int unsigned       take_stall;
  int unsigned       bad_dates;
  secs_item_t        next_item;
  stcd_pkg::result_t seen_date;
  stcd_pkg::result_t want_date;

  function automatic bit is_leap_year(int unsigned y);
    if (y % 400 == 0) return 1'b1;
    return (y % 4 == 0) && (y % 100 != 0);
  endfunction

  function automatic stcd_pkg::result_t calendar_from_seconds(
      logic [stcd_pkg::SECS_W-1:0] secs);
    stcd_pkg::result_t r;
    int unsigned       day_num;
    int unsigned       tod;
    int unsigned       yr;
    int unsigned       ylen;
    int unsigned       mo;
    int unsigned       mlen;
    day_num = secs / 86400 + 1;
    tod     = secs % 86400;
    r.hour   = stcd_pkg::HOUR_W'(tod / 3600);
    r.minute = stcd_pkg::MINUTE_W'((tod % 3600) / 60);
    r.second = stcd_pkg::SECOND_W'(tod % 60);
    yr   = 1970;
    ylen = 365;
    while (day_num > ylen) begin
      day_num -= ylen;
      yr++;
      ylen = is_leap_year(yr) ? 366 : 365;
    end
    mo = 12;
    for (int m = 1; m <= 12; m++) begin
      if (m == 2) mlen = is_leap_year(yr) ? 29 : 28;
      else if (m == 4 || m == 6 || m == 9 || m == 11) mlen = 30;
      else mlen = 31;
      if (day_num <= mlen) begin
        mo = m;
        break;
      end
      day_num -= mlen;
    end
    r.year  = stcd_pkg::YEAR_W'(yr);
    r.month = stcd_pkg::MONTH_W'(mo);
    r.day   = stcd_pkg::DAY_W'(day_num);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Present items at the falling edge; acceptance is seen at the rising edge before.
  always @(negedge clk) begin
    if (rst) begin
      secs_ch.valid <= 1'b0;
    end else if (!secs_ch.valid || secs_taken) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        secs_ch.valid <= 1'b0;
      end else if (pending_secs.size() > 0 &&
                   !(pending_secs[0].drain && dates_due.size() > 0)) begin
        next_item = pending_secs.pop_front();
        secs_ch.valid <= 1'b1;
        secs_ch.epoch_seconds <= next_item.secs;
        if (pending_secs.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 6);
      end else begin
        secs_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      date_ch.ready <= 1'b0;
    end else if (take_stall > 0) begin
      take_stall = take_stall - 1;
      date_ch.ready <= 1'b0;
    end else if (pending_secs.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
      take_stall = $urandom_range(0, 5);
      date_ch.ready <= 1'b0;
    end else begin
      date_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    secs_taken = !rst && secs_ch.valid && secs_ch.ready;
    if (secs_taken) dates_due.push_back(calendar_from_seconds(secs_ch.epoch_seconds));
    if (!rst && date_ch.valid && date_ch.ready) begin
      seen_date = '{year: date_ch.year, month: date_ch.month, day: date_ch.day,
                    hour: date_ch.hour, minute: date_ch.minute, second: date_ch.second};
      if (dates_due.size() == 0) begin
        bad_dates++;
        if (bad_dates <= 10)
          $display("unexpected date %0d-%0d-%0d %0d:%0d:%0d", seen_date.year,
                   seen_date.month, seen_date.day, seen_date.hour, seen_date.minute,
                   seen_date.second);
      end else begin
        want_date = dates_due.pop_front();
        if (seen_date.year !== want_date.year || seen_date.month !== want_date.month ||
            seen_date.day !== want_date.day || seen_date.hour !== want_date.hour ||
            seen_date.minute !== want_date.minute || seen_date.second !== want_date.second)
        begin
          bad_dates++;
          if (bad_dates <= 10)
            $display("date mismatch: want %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                     want_date.year, want_date.month, want_date.day, want_date.hour,
                     want_date.minute, want_date.second, seen_date.year, seen_date.month,
                     seen_date.day, seen_date.hour, seen_date.minute, seen_date.second);
        end
      end
    end
  end

  initial begin
    logic [stcd_pkg::SECS_W-1:0] s;
    int unsigned                 span_days;
    int unsigned                 yy;
    int unsigned                 offs;
    rst                   = 1'b1;
    secs_ch.valid         = 1'b0;
    secs_ch.epoch_seconds = '0;
    date_ch.ready         = 1'b0;
    secs_taken            = 1'b0;
    send_gap              = 0;
    take_stall            = 0;
    bad_dates             = 0;

    for (int k = 0; k < N_DIRECTED; k++)
      pending_secs.push_back('{secs: DIRECTED_SECS[k], drain: (k == N_DIRECTED - 1)});

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 3))
        0, 1: s = $urandom();
        2: begin
          // whole day, at its first or last seconds
          offs = ($urandom_range(0, 1) == 1) ? 86399 - $urandom_range(0, 59)
                                             : $urandom_range(0, 59);
          s = $urandom_range(0, 49709) * 86400 + offs;
        end
        default: begin
          // near a new year, on either side
          yy = $urandom_range(1971, 2106);
          span_days = 0;
          for (int y = 1970; y < yy; y++) span_days += is_leap_year(y) ? 366 : 365;
          offs = $urandom_range(0, 3599);
          s = ($urandom_range(0, 1) == 1) ? span_days * 86400 + offs
                                          : span_days * 86400 - 1 - offs;
        end
      endcase
      pending_secs.push_back('{secs: s, drain: (i % 350 == 175)});
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_secs.size() != 0 || secs_ch.valid || dates_due.size() != 0);
    repeat (200) @(posedge clk);

    if (bad_dates == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
